// ----- rtl/mlpvac_pkg.sv -----
// Shared definitions for the voice activity perceptron: sizes, memory layout,
// load select codes, the sequencer state type and the sigmoid table.
// Has no dependencies; imported by mlp_voice_activity_classifier_top.
`default_nettype none

package mlpvac_pkg;

    localparam int FEATURES     = 5;
    localparam int HIDDEN_ONE   = 32;
    localparam int HIDDEN_TWO   = 16;
    localparam int HIDDEN_THREE = 8;
    localparam int ACT_DEPTH    = 64;

    localparam int W1_BASE = 0;
    localparam int W2_BASE = W1_BASE + HIDDEN_ONE * FEATURES;
    localparam int W3_BASE = W2_BASE + HIDDEN_TWO * HIDDEN_ONE;
    localparam int WO_BASE = W3_BASE + HIDDEN_THREE * HIDDEN_TWO;
    localparam int W_DEPTH = WO_BASE + HIDDEN_THREE;
    localparam int WA_W    = $clog2(W_DEPTH);

    localparam int B1_BASE = 0;
    localparam int B2_BASE = HIDDEN_ONE;
    localparam int B3_BASE = HIDDEN_ONE + HIDDEN_TWO;
    localparam int BO_BASE = HIDDEN_ONE + HIDDEN_TWO + HIDDEN_THREE;
    localparam int B_DEPTH = BO_BASE + 1;
    localparam int BA_W    = $clog2(B_DEPTH);

    localparam int AI_W      = $clog2(ACT_DEPTH);
    localparam int FI_W      = $clog2(FEATURES);
    localparam int DIV_STEPS = 49;
    localparam int ACC_W     = 56;

    localparam logic [3:0] SEL_W1   = 4'd0;
    localparam logic [3:0] SEL_B1   = 4'd1;
    localparam logic [3:0] SEL_W2   = 4'd2;
    localparam logic [3:0] SEL_B2   = 4'd3;
    localparam logic [3:0] SEL_W3   = 4'd4;
    localparam logic [3:0] SEL_B3   = 4'd5;
    localparam logic [3:0] SEL_WO   = 4'd6;
    localparam logic [3:0] SEL_BO   = 4'd7;
    localparam logic [3:0] SEL_MEAN = 4'd8;
    localparam logic [3:0] SEL_STD  = 4'd9;

    localparam logic [1:0] LAYER_OUT = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_DIV, S_NWR, S_BIAS, S_BIASW, S_MAC, S_DRAIN, S_SIG
    } t_state;

    typedef struct packed {
        logic [AI_W-1:0] n_last;
        logic [AI_W-1:0] k_last;
        logic [WA_W-1:0] wbase;
        logic [BA_W-1:0] bbase;
        logic            relu;
    } t_layer_cfg;

    function automatic t_layer_cfg layer_cfg(input logic [1:0] l);
        t_layer_cfg c;
        case (l)
            2'd0: begin
                c = '{AI_W'(HIDDEN_ONE - 1), AI_W'(FEATURES - 1), WA_W'(W1_BASE),
                      BA_W'(B1_BASE), 1'b1};
            end
            2'd1: begin
                c = '{AI_W'(HIDDEN_TWO - 1), AI_W'(HIDDEN_ONE - 1), WA_W'(W2_BASE),
                      BA_W'(B2_BASE), 1'b1};
            end
            2'd2: begin
                c = '{AI_W'(HIDDEN_THREE - 1), AI_W'(HIDDEN_TWO - 1), WA_W'(W3_BASE),
                      BA_W'(B3_BASE), 1'b1};
            end
            default: begin
                c = '{AI_W'(0), AI_W'(HIDDEN_THREE - 1), WA_W'(WO_BASE),
                      BA_W'(BO_BASE), 1'b0};
            end
        endcase
        return c;
    endfunction

    function automatic logic [15:0] sig_tab(input logic [4:0] k);
        logic [15:0] v;
        case (k)
            5'd0:    v = 16'd32768;
            5'd1:    v = 16'd40793;
            5'd2:    v = 16'd47911;
            5'd3:    v = 16'd53581;
            5'd4:    v = 16'd57724;
            5'd5:    v = 16'd60565;
            5'd6:    v = 16'd62428;
            5'd7:    v = 16'd63615;
            5'd8:    v = 16'd64357;
            5'd9:    v = 16'd64816;
            5'd10:   v = 16'd65097;
            5'd11:   v = 16'd65269;
            5'd12:   v = 16'd65374;
            5'd13:   v = 16'd65438;
            5'd14:   v = 16'd65476;
            5'd15:   v = 16'd65500;
            default: v = 16'd65514;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mlp_voice_activity_classifier_top.sv -----
// Voice activity perceptron: parameter store, bit-serial normaliser, shared
// multiply-accumulate sequencer and sigmoid output. Depends on mlpvac_pkg.
`default_nettype none

// A load beat writes one stored parameter and leaves the sequencer idle. A
// classify beat holds o_stall high until its result is registered: each
// feature with a nonzero deviation goes through a one-bit-per-cycle divider,
// and the four layers then run on one 16 by 32 bit multiplier, one
// weight a cycle, with bias fetch and drain steps per neuron. A finished result
// waits in the output register while the next beat is accepted.
module mlp_voice_activity_classifier_top
    import mlpvac_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_req_type,
    input  wire logic [3:0]         i_param_select,
    input  wire logic [5:0]         i_param_row,
    input  wire logic [5:0]         i_param_col,
    input  wire logic signed [31:0] i_param_value,
    input  wire logic signed [31:0] i_feature_zero,
    input  wire logic signed [31:0] i_feature_one,
    input  wire logic signed [31:0] i_feature_two,
    input  wire logic signed [31:0] i_feature_three,
    input  wire logic signed [31:0] i_feature_four,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [15:0]             o_speech_probability,
    output logic                    o_divide_fault
);

    t_state r_state, n_state;

    logic signed [31:0] r_feat [FEATURES];
    logic signed [31:0] r_mean [FEATURES];
    logic signed [31:0] r_std  [FEATURES];

    logic [FI_W-1:0]    r_f, n_f;
    logic               r_fault, n_fault;
    logic [5:0]         r_cnt, n_cnt;
    logic [31:0]        r_rem, n_rem;
    logic [48:0]        r_quo, n_quo;
    logic [31:0]        r_div, n_div;
    logic               r_neg, n_neg;
    logic [1:0]         r_layer, n_layer;
    logic               r_src, n_src;
    logic [AI_W-1:0]    r_i, n_i;
    logic [AI_W-1:0]    r_j, n_j;
    logic [WA_W-1:0]    r_waddr, n_waddr;
    logic               r_v1, n_v1;
    logic               r_v2, n_v2;
    logic signed [47:0] r_prod, n_prod;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [31:0] r_res, n_res;
    logic               r_out_valid, n_out_valid;
    logic [15:0]        r_prob, n_prob;
    logic               r_out_fault, n_out_fault;

    logic [15:0]        m_w   [W_DEPTH];
    logic [15:0]        m_b   [B_DEPTH];
    logic [31:0]        m_act [2*ACT_DEPTH];
    logic [15:0]        r_w_rd, r_b_rd;
    logic [31:0]        r_a_rd;

    logic               w_we, b_we, act_we, feat_we, mean_we, std_we;
    logic [WA_W-1:0]    w_waddr, w_raddr;
    logic [BA_W-1:0]    b_waddr, b_raddr;
    logic [AI_W:0]      act_waddr, act_raddr;
    logic [31:0]        act_wdata;

    logic               in_accept, out_taken;
    t_layer_cfg         cfg;
    logic [6:0]         row7;
    logic               row_lt1, row_lt2, row_lt3, row_ltf, col_lt1, col_lt2, col_lt3;
    logic signed [32:0] diff;
    logic [32:0]        diff_mag;
    logic [31:0]        std_mag;
    logic [32:0]        div_trial;
    logic [31:0]        div_sat;
    logic signed [ACC_W-1:0] rq_t;
    logic signed [ACC_W-13:0] rq_q;
    logic signed [31:0] rq_sat;
    logic [32:0]        sg_abs;
    logic [3:0]         sg_idx;
    logic [15:0]        sg_t0, sg_t1, sg_v;
    logic [30:0]        sg_mul;
    logic [16:0]        sg_out;

    assign in_accept = i_valid && !o_stall;
    assign out_taken = r_out_valid && !i_stall;
    assign o_stall   = (r_state != S_IDLE);
    assign o_valid   = r_out_valid;
    assign o_speech_probability = r_prob;
    assign o_divide_fault       = r_out_fault;
    assign cfg = layer_cfg(r_layer);

    assign row7    = {1'b0, i_param_row};
    assign row_lt1 = row7 < 7'(HIDDEN_ONE);
    assign row_lt2 = row7 < 7'(HIDDEN_TWO);
    assign row_lt3 = row7 < 7'(HIDDEN_THREE);
    assign row_ltf = row7 < 7'(FEATURES);
    assign col_lt1 = {1'b0, i_param_col} < 7'(HIDDEN_ONE);
    assign col_lt2 = {1'b0, i_param_col} < 7'(HIDDEN_TWO);
    assign col_lt3 = {1'b0, i_param_col} < 7'(HIDDEN_THREE);

    assign diff     = 33'(r_feat[r_f]) - 33'(r_mean[r_f]);
    assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    assign std_mag  = r_std[r_f][31] ? 32'(-r_std[r_f]) : 32'(r_std[r_f]);
    assign div_trial = {r_rem, r_quo[48]};

    always_comb begin
        if (r_neg) begin
            if (r_quo > 49'h0_0000_8000_0000) begin
                div_sat = 32'h8000_0000;
            end else begin
                div_sat = 32'(-r_quo[31:0]);
            end
        end else begin
            if (r_quo > 49'h0_0000_7FFF_FFFF) begin
                div_sat = 32'h7FFF_FFFF;
            end else begin
                div_sat = r_quo[31:0];
            end
        end
    end

    assign rq_t = r_acc + ACC_W'(2048);
    assign rq_q = rq_t[ACC_W-1:12];
    always_comb begin
        if (rq_q > (ACC_W-12)'(32'sh7FFF_FFFF)) begin
            rq_sat = 32'sh7FFF_FFFF;
        end else if (rq_q < -(ACC_W-12)'(64'sh8000_0000)) begin
            rq_sat = 32'sh8000_0000;
        end else begin
            rq_sat = rq_q[31:0];
        end
    end

    assign sg_abs = r_res[31] ? 33'(-33'(r_res)) : 33'(r_res);
    assign sg_idx = sg_abs[18:15];
    assign sg_t0  = sig_tab({1'b0, sg_idx});
    assign sg_t1  = sig_tab(5'({1'b0, sg_idx}) + 5'd1);
    assign sg_mul = 31'(sg_t1 - sg_t0) * 31'(sg_abs[14:0]);
    assign sg_v   = (sg_abs >= 33'(32'h0008_0000)) ? sig_tab(5'd16)
                                                   : sg_t0 + sg_mul[30:15];
    assign sg_out = r_res[31] ? 17'h1_0000 - 17'(sg_v) : 17'(sg_v);

    always_comb begin
        n_state     = r_state;
        n_f         = r_f;
        n_fault     = r_fault;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_div       = r_div;
        n_neg       = r_neg;
        n_layer     = r_layer;
        n_src       = r_src;
        n_i         = r_i;
        n_j         = r_j;
        n_waddr     = r_waddr;
        n_v1        = (r_state == S_MAC);
        n_v2        = r_v1;
        n_prod      = $signed(r_w_rd) * $signed(r_a_rd);
        n_acc       = r_v2 ? r_acc + ACC_W'(r_prod) : r_acc;
        n_res       = r_res;
        n_out_valid = out_taken ? 1'b0 : r_out_valid;
        n_prob      = r_prob;
        n_out_fault = r_out_fault;
        w_we      = 1'b0;
        w_waddr   = '0;
        w_raddr   = r_waddr;
        b_we      = 1'b0;
        b_waddr   = '0;
        b_raddr   = cfg.bbase + BA_W'(r_i);
        act_we    = 1'b0;
        act_waddr = '0;
        act_wdata = '0;
        act_raddr = {r_src, r_j};
        feat_we   = 1'b0;
        mean_we   = 1'b0;
        std_we    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_req_type) begin
                        feat_we = 1'b1;
                        n_f     = '0;
                        n_fault = 1'b0;
                        n_state = S_NORM;
                    end else begin
                        case (i_param_select)
                            SEL_W1: begin
                                w_we    = row_lt1 && ({1'b0, i_param_col} < 7'(FEATURES));
                                w_waddr = WA_W'(W1_BASE) + WA_W'(i_param_row)
                                          * WA_W'(FEATURES) + WA_W'(i_param_col);
                            end
                            SEL_W2: begin
                                w_we    = row_lt2 && col_lt1;
                                w_waddr = WA_W'(W2_BASE) + WA_W'(i_param_row)
                                          * WA_W'(HIDDEN_ONE) + WA_W'(i_param_col);
                            end
                            SEL_W3: begin
                                w_we    = row_lt3 && col_lt2;
                                w_waddr = WA_W'(W3_BASE) + WA_W'(i_param_row)
                                          * WA_W'(HIDDEN_TWO) + WA_W'(i_param_col);
                            end
                            SEL_WO: begin
                                w_we    = (i_param_row == 6'd0) && col_lt3;
                                w_waddr = WA_W'(WO_BASE) + WA_W'(i_param_col);
                            end
                            SEL_B1: begin
                                b_we    = row_lt1;
                                b_waddr = BA_W'(B1_BASE) + BA_W'(i_param_row);
                            end
                            SEL_B2: begin
                                b_we    = row_lt2;
                                b_waddr = BA_W'(B2_BASE) + BA_W'(i_param_row);
                            end
                            SEL_B3: begin
                                b_we    = row_lt3;
                                b_waddr = BA_W'(B3_BASE) + BA_W'(i_param_row);
                            end
                            SEL_BO: begin
                                b_we    = (i_param_row == 6'd0);
                                b_waddr = BA_W'(BO_BASE);
                            end
                            SEL_MEAN: mean_we = row_ltf;
                            SEL_STD:  std_we  = row_ltf;
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_NORM: begin
                if (r_std[r_f] == 32'sd0) begin
                    n_fault   = 1'b1;
                    act_we    = 1'b1;
                    act_waddr = {1'b0, AI_W'(r_f)};
                    act_wdata = '0;
                    if (r_f == FI_W'(FEATURES - 1)) begin
                        n_layer = '0;
                        n_src   = 1'b0;
                        n_i     = '0;
                        n_waddr = layer_cfg(2'd0).wbase;
                        n_state = S_BIAS;
                    end else begin
                        n_f = r_f + 1'b1;
                    end
                end else begin
                    n_rem   = '0;
                    n_quo   = {diff_mag, 16'd0};
                    n_div   = std_mag;
                    n_neg   = diff[32] ^ r_std[r_f][31];
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_trial >= {1'b0, r_div}) begin
                    n_rem = 32'(div_trial - {1'b0, r_div});
                    n_quo = {r_quo[47:0], 1'b1};
                end else begin
                    n_rem = div_trial[31:0];
                    n_quo = {r_quo[47:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 6'(DIV_STEPS - 1)) begin
                    n_state = S_NWR;
                end
            end
            S_NWR: begin
                act_we    = 1'b1;
                act_waddr = {1'b0, AI_W'(r_f)};
                act_wdata = div_sat;
                if (r_f == FI_W'(FEATURES - 1)) begin
                    n_layer = '0;
                    n_src   = 1'b0;
                    n_i     = '0;
                    n_waddr = layer_cfg(2'd0).wbase;
                    n_state = S_BIAS;
                end else begin
                    n_f     = r_f + 1'b1;
                    n_state = S_NORM;
                end
            end
            S_BIAS: begin
                n_state = S_BIASW;
            end
            S_BIASW: begin
                n_acc   = {{(ACC_W-32){r_b_rd[15]}}, r_b_rd, 16'd0};
                n_j     = '0;
                n_state = S_MAC;
            end
            S_MAC: begin
                n_waddr = r_waddr + 1'b1;
                n_j     = r_j + 1'b1;
                if (r_j == cfg.k_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    act_we    = 1'b1;
                    act_waddr = {!r_src, r_i};
                    act_wdata = (cfg.relu && rq_sat[31]) ? 32'd0 : rq_sat;
                    if (r_layer == LAYER_OUT) begin
                        n_res   = rq_sat;
                        n_state = S_SIG;
                    end else if (r_i == cfg.n_last) begin
                        n_layer = r_layer + 1'b1;
                        n_src   = !r_src;
                        n_i     = '0;
                        n_waddr = layer_cfg(r_layer + 1'b1).wbase;
                        n_state = S_BIAS;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_BIAS;
                    end
                end
            end
            S_SIG: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_prob      = sg_out[15:0];
                    n_out_fault = r_fault;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f         <= n_f;
        r_fault     <= n_fault;
        r_cnt       <= n_cnt;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_div       <= n_div;
        r_neg       <= n_neg;
        r_layer     <= n_layer;
        r_src       <= n_src;
        r_i         <= n_i;
        r_j         <= n_j;
        r_waddr     <= n_waddr;
        r_prod      <= n_prod;
        r_acc       <= n_acc;
        r_res       <= n_res;
        r_prob      <= n_prob;
        r_out_fault <= n_out_fault;
        if (feat_we) begin
            r_feat[0] <= i_feature_zero;
            r_feat[1] <= i_feature_one;
            r_feat[2] <= i_feature_two;
            r_feat[3] <= i_feature_three;
            r_feat[4] <= i_feature_four;
        end
        if (mean_we) begin
            r_mean[FI_W'(i_param_row)] <= i_param_value;
        end
        if (std_we) begin
            r_std[FI_W'(i_param_row)] <= i_param_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            m_w[w_waddr] <= i_param_value[15:0];
        end
        r_w_rd <= m_w[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            m_b[b_waddr] <= i_param_value[15:0];
        end
        r_b_rd <= m_b[b_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (act_we) begin
            m_act[act_waddr] <= act_wdata;
        end
        r_a_rd <= m_act[act_raddr];
    end

    // The multiply pipeline is empty whenever the sequencer is waiting for a beat.
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_v1 && !r_v2))
        else $error("multiply pipeline busy while idle");

    // The divider never runs past its last quotient bit.
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= 6'(DIV_STEPS - 1)))
        else $error("divider step count overrun");

    // A probability is produced only after the output neuron.
    a_sig_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SIG) |-> (r_layer == LAYER_OUT))
        else $error("sigmoid reached before the output layer");

    // A neuron is written back only once all its products are accumulated.
    a_drain_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && act_we) |-> (!r_v1 && !r_v2))
        else $error("neuron written before accumulation finished");

    // The output register is loaded only on leaving the sigmoid state.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && n_out_valid) |-> (r_state == S_SIG))
        else $error("result raised outside the sigmoid state");

endmodule

`default_nettype wire
